@@ hdl/rwlu_pkg.sv @@
// Package with the action codes, error codes and shared types of the reader-writer lock unit.
`default_nettype none

package rwlu_pkg;

    localparam int ACT_W       = 3;
    localparam int ID_W        = 4;
    localparam int OUT_COUNT_W = 10;
    localparam int ERR_W       = 2;

    localparam logic [ACT_W-1:0] ACT_ACQ_EXCL   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ACQ_SHARED = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REL_EXCL   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REL_SHARED = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TRY_EXCL   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_TRY_SHARED = 3'd5;
    localparam logic [ACT_W-1:0] ACT_EXCL_CLAIM = 3'd6;
    localparam logic [ACT_W-1:0] ACT_INIT       = 3'd7;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [ERR_W-1:0] ERR_MISMATCH = 2'd2;

    typedef struct packed {
        logic             granted;
        logic             queued;
        logic             wake_exclusive;
        logic [ERR_W-1:0] error_code;
    } rwlu_flags_t;

endpackage

`default_nettype wire

@@ hdl/rwlu_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module rwlu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wen,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              ren,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/rwlu_step.sv @@
// Read-modify-write logic that applies one lock request to one lock word.
`default_nettype none

module rwlu_step #(
    parameter int COUNT_BITS = 10,
    localparam int WORD_W = 3 * COUNT_BITS + 2
) (
    input  wire logic [rwlu_pkg::ACT_W-1:0] action,
    input  wire logic [WORD_W-1:0]          word_in,
    output logic      [WORD_W-1:0]          word_out,
    output rwlu_pkg::rwlu_flags_t           flags,
    output logic      [COUNT_BITS-1:0]      wake_shared
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    logic                  owned;
    logic                  waking;
    logic [COUNT_BITS-1:0] readers;
    logic [COUNT_BITS-1:0] rwait;
    logic [COUNT_BITS-1:0] wwait;

    assign owned   = word_in[0];
    assign waking  = word_in[1];
    assign readers = word_in[COUNT_BITS+1:2];
    assign rwait   = word_in[2*COUNT_BITS+1:COUNT_BITS+2];
    assign wwait   = word_in[3*COUNT_BITS+1:2*COUNT_BITS+2];

    always_comb
    begin
        logic                  n_owned;
        logic                  n_waking;
        logic [COUNT_BITS-1:0] n_readers;
        logic [COUNT_BITS-1:0] n_rwait;
        logic [COUNT_BITS-1:0] n_wwait;
        logic                  excl_pending;
        logic                  can_share;

        n_owned      = owned;
        n_waking     = waking;
        n_readers    = readers;
        n_rwait      = rwait;
        n_wwait      = wwait;
        excl_pending = waking || (wwait != '0);
        can_share    = !excl_pending && (!owned || (readers != '0));
        flags        = '0;
        flags.error_code = rwlu_pkg::ERR_NONE;
        wake_shared  = '0;

        unique case (action) inside
            rwlu_pkg::ACT_ACQ_EXCL:
            begin
                if (!owned && !waking)
                begin
                    n_owned       = 1'b1;
                    flags.granted = 1'b1;
                end
                else if (wwait == COUNT_MAX)
                begin
                    flags.error_code = rwlu_pkg::ERR_OVERFLOW;
                end
                else
                begin
                    n_wwait      = wwait + COUNT_ONE;
                    flags.queued = 1'b1;
                end
            end
            rwlu_pkg::ACT_ACQ_SHARED, rwlu_pkg::ACT_TRY_SHARED:
            begin
                if (can_share)
                begin
                    if (readers == COUNT_MAX)
                    begin
                        flags.error_code = rwlu_pkg::ERR_OVERFLOW;
                    end
                    else
                    begin
                        n_owned       = 1'b1;
                        n_readers     = readers + COUNT_ONE;
                        flags.granted = 1'b1;
                    end
                end
                else if (action == rwlu_pkg::ACT_ACQ_SHARED)
                begin
                    if (rwait == COUNT_MAX)
                    begin
                        flags.error_code = rwlu_pkg::ERR_OVERFLOW;
                    end
                    else
                    begin
                        n_rwait      = rwait + COUNT_ONE;
                        flags.queued = 1'b1;
                    end
                end
            end
            rwlu_pkg::ACT_REL_EXCL:
            begin
                if (!owned || (readers != '0))
                begin
                    flags.error_code = rwlu_pkg::ERR_MISMATCH;
                end
                else if (wwait != '0)
                begin
                    n_owned              = 1'b0;
                    n_waking             = 1'b1;
                    n_wwait              = wwait - COUNT_ONE;
                    flags.wake_exclusive = 1'b1;
                end
                else
                begin
                    n_owned     = 1'b0;
                    wake_shared = rwait;
                    n_rwait     = '0;
                end
            end
            rwlu_pkg::ACT_REL_SHARED:
            begin
                if (!owned || (readers == '0))
                begin
                    flags.error_code = rwlu_pkg::ERR_MISMATCH;
                end
                else if (readers > COUNT_ONE)
                begin
                    n_readers = readers - COUNT_ONE;
                end
                else if (wwait != '0)
                begin
                    n_owned              = 1'b0;
                    n_readers            = '0;
                    n_waking             = 1'b1;
                    n_wwait              = wwait - COUNT_ONE;
                    flags.wake_exclusive = 1'b1;
                end
                else
                begin
                    n_owned   = 1'b0;
                    n_readers = '0;
                end
            end
            rwlu_pkg::ACT_TRY_EXCL:
            begin
                if (!owned && !waking)
                begin
                    n_owned       = 1'b1;
                    flags.granted = 1'b1;
                end
            end
            rwlu_pkg::ACT_EXCL_CLAIM:
            begin
                if (!waking || owned)
                begin
                    flags.error_code = rwlu_pkg::ERR_MISMATCH;
                end
                else
                begin
                    n_waking      = 1'b0;
                    n_owned       = 1'b1;
                    flags.granted = 1'b1;
                end
            end
            rwlu_pkg::ACT_INIT:
            begin
                n_owned   = 1'b0;
                n_waking  = 1'b0;
                n_readers = '0;
                n_rwait   = '0;
                n_wwait   = '0;
            end
            default:
            begin
                n_owned = owned;
            end
        endcase

        word_out = {n_wwait, n_rwait, n_readers, n_waking, n_owned};
    end

endmodule

`default_nettype wire

@@ hdl/reader_writer_lock_unit_core.sv @@
// Top level of the reader-writer lock unit: lock word RAM, request sequencing and result register.
//
//  Channel  | Direction | Contents
//  s_axis   | in        | one request: action, lock_id
//  m_axis   | out       | one result per request: grant, queue, wake and error flags, new counts
//
// For each request the lock word is first read from the RAM, then modified and written
// back; a new request is not taken while one is in flight.
// After reset the RAM is cleared one word a cycle, all LOCK_COUNT words, with s_axis_tready low.
// A result waits in the output register while m_axis_tready is low; a following request
// may still be read, and its write-back waits until the output register is free.
`default_nettype none

module reader_writer_lock_unit_core #(
    parameter int LOCK_COUNT = 16,
    parameter int COUNT_BITS = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] action, [6:3] lock_id, [7] zero
    input  wire logic [7:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] granted, [1] queued, [2] wake_exclusive, [12:3] wake_shared_count,
    // [14:13] error_code, [15] owned_now, [16] waking_now, [26:17] readers_now,
    // [36:27] reader_waiters_now, [46:37] writer_waiters_now, [47] zero
    output logic [47:0]      m_axis_tdata
);

    localparam int WORD_W   = 3 * COUNT_BITS + 2;
    localparam int ADDR_W   = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
    localparam int IDX_W    = (ADDR_W > rwlu_pkg::ID_W) ? ADDR_W : rwlu_pkg::ID_W;
    localparam int EXT_W    = (COUNT_BITS > rwlu_pkg::OUT_COUNT_W) ?
                              COUNT_BITS : rwlu_pkg::OUT_COUNT_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LOCK_COUNT - 1);
    localparam logic [IDX_W:0]    COUNT_LIM = (IDX_W + 1)'(LOCK_COUNT);

    logic [rwlu_pkg::ACT_W-1:0] in_action;
    logic [rwlu_pkg::ID_W-1:0]  in_lock_id;
    logic [IDX_W-1:0]           in_idx;
    logic                       in_range;
    logic                       accept;
    logic                       fire;

    logic                       clearing_reg, clearing_next;
    logic [ADDR_W-1:0]          clr_addr_reg, clr_addr_next;
    logic                       pend_reg, pend_next;
    logic                       range_reg, range_next;
    logic [rwlu_pkg::ACT_W-1:0] act_reg, act_next;
    logic [ADDR_W-1:0]          addr_reg, addr_next;
    logic                       out_valid_reg, out_valid_next;
    logic [47:0]                out_data_reg, out_data_next;

    logic                       ram_wen;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [WORD_W-1:0]          ram_wdata;
    logic [WORD_W-1:0]          ram_rdata;
    logic [WORD_W-1:0]          word_new;
    rwlu_pkg::rwlu_flags_t      step_flags;
    logic [COUNT_BITS-1:0]      step_wake;

    assign in_action  = s_axis_tdata[2:0];
    assign in_lock_id = s_axis_tdata[6:3];
    assign in_idx     = IDX_W'(in_lock_id);
    assign in_range   = {1'b0, in_idx} < COUNT_LIM;

    assign s_axis_tready = !clearing_reg && !pend_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign fire          = pend_reg && (!out_valid_reg || m_axis_tready);

    rwlu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LOCK_COUNT)
    ) u_ram (
        .clk   (clk),
        .wen   (ram_wen),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .ren   (accept && in_range),
        .raddr (in_idx[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    rwlu_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .action      (act_reg),
        .word_in     (ram_rdata),
        .word_out    (word_new),
        .flags       (step_flags),
        .wake_shared (step_wake)
    );

    always_comb
    begin
        logic [EXT_W-1:0] wake_ext;
        logic [EXT_W-1:0] rd_ext;
        logic [EXT_W-1:0] rw_ext;
        logic [EXT_W-1:0] ww_ext;

        wake_ext = EXT_W'(step_wake);
        rd_ext   = EXT_W'(word_new[COUNT_BITS+1:2]);
        rw_ext   = EXT_W'(word_new[2*COUNT_BITS+1:COUNT_BITS+2]);
        ww_ext   = EXT_W'(word_new[3*COUNT_BITS+1:2*COUNT_BITS+2]);

        clearing_next  = clearing_reg;
        clr_addr_next  = clr_addr_reg;
        pend_next      = pend_reg;
        range_next     = range_reg;
        act_next       = act_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_wen        = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = word_new;

        if (clearing_reg)
        begin
            ram_wen   = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
            if (clr_addr_reg == LAST_ADDR)
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
        end

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (fire)
        begin
            pend_next      = 1'b0;
            out_valid_next = 1'b1;
            if (range_reg)
            begin
                ram_wen       = 1'b1;
                out_data_next = {1'b0,
                                 ww_ext[rwlu_pkg::OUT_COUNT_W-1:0],
                                 rw_ext[rwlu_pkg::OUT_COUNT_W-1:0],
                                 rd_ext[rwlu_pkg::OUT_COUNT_W-1:0],
                                 word_new[1],
                                 word_new[0],
                                 step_flags.error_code,
                                 wake_ext[rwlu_pkg::OUT_COUNT_W-1:0],
                                 step_flags.wake_exclusive,
                                 step_flags.queued,
                                 step_flags.granted};
            end
            else
            begin
                out_data_next = '0;
            end
        end

        if (accept)
        begin
            pend_next  = 1'b1;
            range_next = in_range;
            act_next   = in_action;
            addr_next  = in_idx[ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        range_reg    <= range_next;
        act_reg      <= act_next;
        addr_reg     <= addr_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !accept)
        else $error("request accepted during the RAM clearing pass");

    a_pending_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && !fire) |=> pend_reg)
        else $error("pending request dropped without a result");

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_axis_tvalid)
        else $error("finished request did not produce a result");

    a_write_only_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wen && !clearing_reg) |-> (fire && range_reg))
        else $error("lock word written outside a completing request");

    a_no_read_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !accept)
        else $error("second request read before the first was written back");
`endif

endmodule

`default_nettype wire
